### hdl/assert_macros.svh
// Assertion macros shared by the deque engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of clk outside of reset.
`define DQE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a consequent holds whenever an antecedent holds, outside of reset.
`define DQE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hdl/dqe_pkg.sv
// Types, codes and constants of the bounded deque engine.
package dqe_pkg;

  localparam int DQE_DEPTH_DEF = 16;
  localparam int DQE_DATA_W    = 32;
  localparam int DQE_FUNC_W    = 3;
  localparam int DQE_STATUS_W  = 2;

  localparam logic [DQE_FUNC_W-1:0] FUNC_INS_FRONT = 3'd0;
  localparam logic [DQE_FUNC_W-1:0] FUNC_REM_FRONT = 3'd1;
  localparam logic [DQE_FUNC_W-1:0] FUNC_INS_BACK  = 3'd2;
  localparam logic [DQE_FUNC_W-1:0] FUNC_REM_BACK  = 3'd3;
  localparam logic [DQE_FUNC_W-1:0] FUNC_LIST      = 3'd4;

  localparam logic [DQE_STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [DQE_STATUS_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [DQE_STATUS_W-1:0] STAT_FULL  = 2'd2;

  typedef enum logic {
    S_IDLE,
    S_LIST
  } state_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_PUSH_FRONT,
    CMD_PUSH_BACK,
    CMD_POP_FRONT,
    CMD_ROTATE
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t                     cmd;
    logic signed [DQE_DATA_W-1:0]  value;
  } cell_ctrl_t;

endpackage

### hdl/dqe_cell.sv
// One storage cell of the deque chain; cell 0 always holds the front entry.
module dqe_cell #(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic                                  clk,
  input  dqe_pkg::cell_ctrl_t                   ctrl,
  input  logic [$clog2(DEPTH+1)-1:0]            count,
  input  logic signed [dqe_pkg::DQE_DATA_W-1:0] left_data,
  input  logic signed [dqe_pkg::DQE_DATA_W-1:0] right_data,
  input  logic signed [dqe_pkg::DQE_DATA_W-1:0] head_data,
  output logic signed [dqe_pkg::DQE_DATA_W-1:0] data_o
);
  import dqe_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] MY_IDX  = CW'(IDX);
  localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);

  logic signed [DQE_DATA_W-1:0] data_r;
  logic signed [DQE_DATA_W-1:0] data_nxt;

  always_comb begin
    case (ctrl.cmd)
      CMD_PUSH_FRONT: data_nxt = (IDX == 0) ? ctrl.value : left_data;
      CMD_PUSH_BACK:  data_nxt = (count == MY_IDX) ? ctrl.value : data_r;
      CMD_POP_FRONT:  data_nxt = right_data;
      CMD_ROTATE:     data_nxt = (count == MY_NEXT) ? head_data : right_data;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

### hdl/bounded_deque_engine.sv
// Bounded double-ended queue of signed 32-bit words; insert and remove at both ends, and list.
// The entries sit in a row of DEPTH cells with the front entry always in cell 0, so inserts
// and removes at the front shift the whole row at once; an insert or remove returns a status
// and an unused code gives no result. A list beat first enters the list state and then streams
// one entry per cycle while the output register is free, as the row rotates past cell 0; a
// list of an empty queue answers with the empty status. Inputs are not taken while a list is
// streaming or while a result waits in the output register with out_tready low.
module bounded_deque_engine #(
  parameter int DEPTH = dqe_pkg::DQE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [dqe_pkg::DQE_DATA_W-1:0]        in_tdata,   // [31:0] value
  input  logic [dqe_pkg::DQE_FUNC_W-1:0]        in_tuser,   // [2:0] func
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [dqe_pkg::DQE_DATA_W-1:0]        out_tdata,  // [31:0] item_value
  output logic [dqe_pkg::DQE_STATUS_W-1:0]      out_tuser,  // [1:0] status
  output logic                                  out_tlast
);
  import dqe_pkg::*;
`include "assert_macros.svh"

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
  localparam logic [CW-1:0] ONE        = CW'(1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;

  logic                         out_valid_r;
  logic [DQE_DATA_W-1:0]        out_data_r;
  logic [DQE_STATUS_W-1:0]      out_status_r;
  logic                         out_last_r;

  logic                         out_load;
  logic [DQE_DATA_W-1:0]        load_data;
  logic [DQE_STATUS_W-1:0]      load_status;
  logic                         load_last;

  logic out_free;
  logic in_accept;
  logic is_full;
  logic is_empty;
  logic list_last;

  cell_ctrl_t ctrl;
  logic signed [DQE_DATA_W-1:0] cell_data [DEPTH];

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_accept = in_tvalid && in_tready;
  assign is_full   = (count_r == FULL_COUNT);
  assign is_empty  = (count_r == '0);
  assign list_last = (idx_r == count_r - ONE);

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [DQE_DATA_W-1:0] left_d;
      logic signed [DQE_DATA_W-1:0] right_d;
      if (g == 0) begin : g_first
        assign left_d = ctrl.value;
      end else begin : g_mid
        assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_last
        assign right_d = cell_data[0];
      end else begin : g_inner
        assign right_d = cell_data[g+1];
      end
      dqe_cell #(
        .DEPTH (DEPTH),
        .IDX   (g)
      ) u_cell (
        .clk        (clk),
        .ctrl       (ctrl),
        .count      (count_r),
        .left_data  (left_d),
        .right_data (right_d),
        .head_data  (cell_data[0]),
        .data_o     (cell_data[g])
      );
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_accept && in_tuser == FUNC_LIST && !is_empty) begin
          state_nxt = S_LIST;
        end
      end
      S_LIST: begin
        if (out_free && list_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl.cmd    = CMD_HOLD;
    ctrl.value  = $signed(in_tdata);
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    out_load    = 1'b0;
    load_data   = '0;
    load_status = STAT_OK;
    load_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          case (in_tuser)
            FUNC_INS_FRONT, FUNC_INS_BACK: begin
              out_load = 1'b1;
              if (is_full) begin
                load_status = STAT_FULL;
              end else begin
                ctrl.cmd  = (in_tuser == FUNC_INS_FRONT) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
                count_nxt = count_r + ONE;
              end
            end
            FUNC_REM_FRONT, FUNC_REM_BACK: begin
              out_load = 1'b1;
              if (is_empty) begin
                load_status = STAT_EMPTY;
              end else begin
                ctrl.cmd  = (in_tuser == FUNC_REM_FRONT) ? CMD_POP_FRONT : CMD_HOLD;
                count_nxt = count_r - ONE;
              end
            end
            FUNC_LIST: begin
              if (is_empty) begin
                out_load    = 1'b1;
                load_status = STAT_EMPTY;
              end else begin
                idx_nxt = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_LIST: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_data = cell_data[0];
          load_last = list_last;
          ctrl.cmd  = CMD_ROTATE;
          idx_nxt   = idx_r + ONE;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r   <= load_data;
      out_status_r <= load_status;
      out_last_r   <= load_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  `DQE_ASSERT(a_count_bound, count_r <= FULL_COUNT, "entry count exceeds depth")
  `DQE_ASSERT_IMP(a_list_range, state_r == S_LIST, !is_empty && idx_r < count_r, "list index out of range")
  `DQE_ASSERT_IMP(a_ins_count, in_accept && !is_full && (in_tuser == FUNC_INS_FRONT || in_tuser == FUNC_INS_BACK), ##1 count_r == $past(count_r) + ONE, "insert did not grow the queue")
  `DQE_ASSERT_IMP(a_list_end, state_r == S_LIST && out_free && list_last, ##1 state_r == S_IDLE && out_tlast, "list did not end on its final entry")

endmodule
